### design/oite_pkg.sv
// Shared types and codes for the ordered id table engine.
package oite_pkg;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_DUP      = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam int COUNT_OUT_W = 4;

  typedef struct packed {
    logic accept;
    logic rd_search;
    logic rd_shift;
    logic wr_shift;
    logic idx_inc;
    logic set_hit;
    logic append;
    logic dec_count;
    logic decide;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       hit;
    logic       at_end;
    logic       match;
    logic       full;
    logic       shift_done;
    logic       out_busy;
  } dp_sts_t;

endpackage

### design/oite_dp.sv
// Datapath: request latch, entry memory, scan index, fill count and result register.
module oite_dp import oite_pkg::*; #(
  parameter int ENTRIES     = 8,
  parameter int KEY_WIDTH   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ctrl_cmd_t              cmd,
  output dp_sts_t                sts,
  input  logic [1:0]             mode,
  input  logic [KEY_WIDTH-1:0]   key_id,
  input  logic [VALUE_WIDTH-1:0] entry_value,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic [1:0]             status,
  output logic                   hit,
  output logic [VALUE_WIDTH-1:0] found_value,
  output logic [COUNT_OUT_W-1:0] entry_count
);

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int EW = KEY_WIDTH + VALUE_WIDTH;

  logic [1:0]             req_mode;
  logic [KEY_WIDTH-1:0]   req_key;
  logic [VALUE_WIDTH-1:0] req_value;
  logic [CW-1:0]          idx;
  logic [CW-1:0]          count;
  logic                   hit_r;
  logic [EW-1:0]          rdata;
  logic [EW-1:0]          mem [ENTRIES];

  logic [CW:0]            idx_plus;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          wr_addr;
  logic [EW-1:0]          wdata;

  logic [1:0]             res_status;
  logic                   res_hit;
  logic [VALUE_WIDTH-1:0] res_value;
  logic [1:0]             res_status_next;
  logic                   res_hit_next;
  logic [VALUE_WIDTH-1:0] res_value_next;

  assign idx_plus = {1'b0, idx} + 1'b1;
  assign rd_addr  = cmd.rd_shift ? idx_plus[AW-1:0] : idx[AW-1:0];
  assign wr_addr  = cmd.append ? count[AW-1:0] : idx[AW-1:0];
  assign wdata    = cmd.append ? {req_key, req_value} : rdata;

  assign sts.mode       = req_mode;
  assign sts.hit        = hit_r;
  assign sts.at_end     = (idx == count);
  assign sts.match      = (rdata[EW-1:VALUE_WIDTH] == req_key);
  assign sts.full       = (count == CW'(ENTRIES));
  assign sts.shift_done = (idx_plus >= {1'b0, count});
  assign sts.out_busy   = out_valid & out_stall;

  always_ff @(posedge clk) begin
    if (cmd.append || cmd.wr_shift) begin
      mem[wr_addr] <= wdata;
    end
    if (cmd.rd_search || cmd.rd_shift) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_mode  <= mode;
      req_key   <= key_id;
      req_value <= entry_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      count <= '0;
      hit_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        idx   <= '0;
        hit_r <= 1'b0;
      end else if (cmd.idx_inc) begin
        idx <= idx_plus[CW-1:0];
      end
      if (cmd.set_hit) begin
        hit_r <= 1'b1;
      end
      if (cmd.append) begin
        count <= count + 1'b1;
      end else if (cmd.dec_count) begin
        count <= count - 1'b1;
      end
    end
  end

  // Result of the request; the matched entry still sits in rdata on a lookup hit.
  always_comb begin
    res_status_next = ST_OK;
    res_hit_next    = 1'b0;
    res_value_next  = '0;
    case (req_mode)
      MODE_INSERT: begin
        res_hit_next = hit_r;
        if (hit_r) begin
          res_status_next = ST_DUP;
        end else if (sts.full) begin
          res_status_next = ST_FULL;
        end
      end
      MODE_REMOVE: begin
        res_hit_next = hit_r;
        if (!hit_r) begin
          res_status_next = ST_NOTFOUND;
        end
      end
      MODE_LOOKUP: begin
        res_hit_next = hit_r;
        if (hit_r) begin
          res_value_next = rdata[VALUE_WIDTH-1:0];
        end else begin
          res_status_next = ST_NOTFOUND;
        end
      end
      default: begin
        res_status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      res_status <= res_status_next;
      res_hit    <= res_hit_next;
      res_value  <= res_value_next;
    end
    if (cmd.load_out) begin
      status      <= res_status;
      hit         <= res_hit;
      found_value <= res_value;
      entry_count <= COUNT_OUT_W'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### design/oite_ctrl.sv
// Controller: sequences scan, update, compaction and result hand-off.
module oite_ctrl import oite_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_READ     = 3'd1;
  localparam logic [2:0] S_CMP      = 3'd2;
  localparam logic [2:0] S_DECIDE   = 3'd3;
  localparam logic [2:0] S_SH_READ  = 3'd4;
  localparam logic [2:0] S_SH_WRITE = 3'd5;
  localparam logic [2:0] S_FINISH   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (sts.at_end) begin
          state_next = S_DECIDE;
        end else begin
          cmd.rd_search = 1'b1;
          state_next    = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.match) begin
          cmd.set_hit = 1'b1;
          state_next  = S_DECIDE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_READ;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = S_FINISH;
        if (sts.mode == MODE_INSERT && !sts.hit && !sts.full) begin
          cmd.append = 1'b1;
        end
        // idx still points at the match: close the gap from there
        if (sts.mode == MODE_REMOVE && sts.hit) begin
          state_next = S_SH_READ;
        end
      end
      S_SH_READ: begin
        if (sts.shift_done) begin
          cmd.dec_count = 1'b1;
          state_next    = S_FINISH;
        end else begin
          cmd.rd_shift = 1'b1;
          state_next   = S_SH_WRITE;
        end
      end
      S_SH_WRITE: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_next   = S_SH_READ;
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### design/ordered_id_table_engine.sv
// Top level of the ordered id table engine: controller, datapath and checks.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+---------------------------------------------
//   in      | in_valid  | in_stall  | mode, key_id, entry_value
//   out     | out_valid | out_stall | status, hit, found_value, entry_count
//
// One transaction at a time; the key scan reads and compares each stored entry in turn
// (S_READ, S_CMP) and stops at the first match or at the end of the table. A remove that hits
// then moves each later entry down one slot (S_SH_READ, S_SH_WRITE) before the result is loaded.
// Synchronous reset empties the table at once (no clearing pass). in_stall is high from
// acceptance until the result is loaded; a stalled output holds the next result in its
// staging register until the slot frees.
module ordered_id_table_engine import oite_pkg::*; #(
  parameter int ENTRIES     = 8,
  parameter int KEY_WIDTH   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             mode,
  input  logic [KEY_WIDTH-1:0]   key_id,
  input  logic [VALUE_WIDTH-1:0] entry_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             status,
  output logic                   hit,
  output logic [VALUE_WIDTH-1:0] found_value,
  output logic [COUNT_OUT_W-1:0] entry_count
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  oite_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  oite_dp #(
    .ENTRIES     (ENTRIES),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .mode        (mode),
    .key_id      (key_id),
    .entry_value (entry_value),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .status      (status),
    .hit         (hit),
    .found_value (found_value),
    .entry_count (entry_count)
  );

  a_dup_has_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_DUP) |-> hit)
    else $error("duplicate status without hit");

  a_notfound_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_NOTFOUND) |-> !hit && (found_value == '0))
    else $error("not-found result carries hit or value");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> !hit && (entry_count == COUNT_OUT_W'(ENTRIES)))
    else $error("full status with table not full");

  a_no_write_clash: assert property (@(posedge clk) disable iff (rst)
    !(cmd.append && cmd.wr_shift))
    else $error("append and compaction write in the same cycle");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");

endmodule
